// File: sv/alcb_pkg.sv
// -----------------------------------------------------------------------------
// alcb_pkg
// Shared types, constants and the level power table of the audio level color
// blender.
// -----------------------------------------------------------------------------
package alcb_pkg;

   // Sample and level formats.
   localparam int SAMPLE_W         = 24;
   localparam int SAMPLE_FRAC_BITS = 23;
   localparam int LEVEL_BITS       = 16;
   localparam int TABLE_INDEX_BITS = 10;
   localparam int MAX_FRAMES       = 4096;
   localparam int COLOR_W          = 8;

   localparam int SUM_W      = 35;
   localparam int COUNT_W    = $clog2(MAX_FRAMES + 1);
   localparam int TABLE_SIZE = 1 << TABLE_INDEX_BITS;
   localparam int LEVEL_MAX  = (1 << LEVEL_BITS) - 1;

   // The mean becomes a table index by a shift in one direction or the other.
   localparam int IDX_RSHIFT = (SAMPLE_FRAC_BITS >= TABLE_INDEX_BITS) ?
                               SAMPLE_FRAC_BITS - TABLE_INDEX_BITS : 0;
   localparam int IDX_LSHIFT = (SAMPLE_FRAC_BITS >= TABLE_INDEX_BITS) ?
                               0 : TABLE_INDEX_BITS - SAMPLE_FRAC_BITS;

   // Configuration register file.
   localparam int CSR_ADDR_W = 3;
   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_BASE_RED    = 3'd0,
      CSR_BASE_GREEN  = 3'd1,
      CSR_BASE_BLUE   = 3'd2,
      CSR_BOOST_RED   = 3'd3,
      CSR_BOOST_GREEN = 3'd4,
      CSR_BOOST_BLUE  = 3'd5
   } alcb_csr_type;

   localparam logic [COLOR_W-1:0] BASE_RED_RESET    = 8'h7f;
   localparam logic [COLOR_W-1:0] BASE_GREEN_RESET  = 8'h25;
   localparam logic [COLOR_W-1:0] BASE_BLUE_RESET   = 8'h50;
   localparam logic [COLOR_W-1:0] BOOST_RED_RESET   = 8'hff;
   localparam logic [COLOR_W-1:0] BOOST_GREEN_RESET = 8'h00;
   localparam logic [COLOR_W-1:0] BOOST_BLUE_RESET  = 8'h00;

   // Channel payloads.
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       block_end;
   } alcb_req_type;

   typedef struct packed {
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
   } alcb_rsp_type;

   // Divider interface.
   typedef struct packed {
      logic               start;
      logic [SUM_W-1:0]   dividend;
      logic [COUNT_W-1:0] divisor;
   } alcb_div_req_type;

   typedef struct packed {
      logic             done;
      logic [SUM_W-1:0] quotient;
   } alcb_div_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_LEVEL,
      ST_BLEND,
      ST_OUT
   } alcb_state_type;

   typedef enum logic [1:0] {
      CH_RED,
      CH_GREEN,
      CH_BLUE
   } alcb_chan_type;

   // Power table: entry i is the largest y below 1.0 with
   // y^50 <= (i / TABLE_SIZE)^33 in fixed point, i.e. floor of x^0.66 scaled.
   // It is built exactly with wide integers while the design elaborates.
   localparam int EXP_NUM   = 33;
   localparam int EXP_DEN   = 50;
   localparam int POW_SHIFT = EXP_DEN * LEVEL_BITS - EXP_NUM * TABLE_INDEX_BITS;
   localparam int BIG_W     = EXP_DEN * LEVEL_BITS + 2;

   typedef logic [BIG_W-1:0] alcb_big_type;
   typedef logic [TABLE_SIZE-1:0][LEVEL_BITS-1:0] alcb_pow_table_type;

   function automatic alcb_big_type big_pow(input alcb_big_type base, input int ex);
      alcb_big_type r;
      alcb_big_type b;
      int           e;
      r = alcb_big_type'(1);
      b = base;
      e = ex;
      while (e > 0) begin
         if (e[0]) begin
            r = r * b;
         end
         e = e >> 1;
         if (e > 0) begin
            b = b * b;
         end
      end
      return r;
   endfunction

   function automatic alcb_pow_table_type build_pow_table();
      alcb_pow_table_type tbl;
      alcb_big_type       rhs;
      int                 lo;
      int                 hi;
      int                 mid;
      lo = 0;
      for (int i = 0; i < TABLE_SIZE; i++) begin
         rhs = big_pow(alcb_big_type'(i), EXP_NUM) << POW_SHIFT;
         hi  = LEVEL_MAX;
         // The table rises with i, so the search starts at the last entry.
         while (lo < hi) begin
            mid = lo + ((hi - lo + 1) >> 1);
            if (big_pow(alcb_big_type'(mid), EXP_DEN) <= rhs) begin
               lo = mid;
            end else begin
               hi = mid - 1;
            end
         end
         tbl[i] = LEVEL_BITS'(lo);
      end
      return tbl;
   endfunction

   localparam alcb_pow_table_type POW_TABLE = build_pow_table();

endpackage

// File: sv/alcb_divider.sv
// -----------------------------------------------------------------------------
// alcb_divider
// Restoring divider that produces one quotient bit per cycle.
// -----------------------------------------------------------------------------
module alcb_divider (
   input  logic                       clock,
   input  logic                       reset,
   input  alcb_pkg::alcb_div_req_type div_req,
   output alcb_pkg::alcb_div_rsp_type div_rsp
);
   import alcb_pkg::*;

   localparam int STEP_W = $clog2(SUM_W + 1);

   logic                busy_ff;
   logic                done_ff;
   logic [STEP_W-1:0]   step_ff;
   logic [SUM_W-1:0]    quot_ff;
   logic [COUNT_W-1:0]  rem_ff;
   logic [COUNT_W-1:0]  divisor_ff;

   logic [COUNT_W:0]    shifted;
   logic [COUNT_W:0]    trial;
   logic                fits;

   always_comb begin
      shifted = {rem_ff, quot_ff[SUM_W-1]};
      trial   = shifted - {1'b0, divisor_ff};
      fits    = shifted >= {1'b0, divisor_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            step_ff <= STEP_W'(SUM_W);
         end else if (busy_ff) begin
            step_ff <= step_ff - 1'b1;
            if (step_ff == STEP_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // The remainder always stays below the divisor, so it fits COUNT_W bits.
   always_ff @(posedge clock) begin
      if (div_req.start) begin
         quot_ff    <= div_req.dividend;
         rem_ff     <= '0;
         divisor_ff <= div_req.divisor;
      end else if (busy_ff) begin
         quot_ff <= {quot_ff[SUM_W-2:0], fits};
         rem_ff  <= fits ? trial[COUNT_W-1:0] : shifted[COUNT_W-1:0];
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quot_ff;

endmodule

// File: sv/audio_level_color_blend.sv
// -----------------------------------------------------------------------------
// audio_level_color_blend
// Turns the mean audio level of each capture block into a blended RGB color.
// -----------------------------------------------------------------------------
// Frames are taken one per cycle while the block is idle; each frame up to the
// frame cap adds its saturated sample magnitude to a running sum. A request
// with block_end set closes the block: the sum is divided by the frame count
// in a bit-serial divider (one quotient bit per cycle), the mean goes through
// the x^0.66 table and the two-step level smoothing, and one shared multiplier
// blends the three color channels in turn. From the closing request until the
// result is registered for output the block stalls requests, longer if the
// previous result is still held on the response side. Configuration writes are meant for idle periods only.
module audio_level_color_blend (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  alcb_pkg::alcb_req_type             req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output alcb_pkg::alcb_rsp_type             rsp_data,
   input  logic                               csr_we,
   input  logic [alcb_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [alcb_pkg::COLOR_W-1:0]       csr_wdata
);
   import alcb_pkg::*;

   localparam logic [SAMPLE_W:0] MAG_ONE = (SAMPLE_W + 1)'(1) << SAMPLE_FRAC_BITS;
   localparam int IDX_W = SUM_W + IDX_LSHIFT;

   // Configuration registers.
   logic [COLOR_W-1:0] base_red_ff, base_green_ff, base_blue_ff;
   logic [COLOR_W-1:0] boost_red_ff, boost_green_ff, boost_blue_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_red_ff    <= BASE_RED_RESET;
         base_green_ff  <= BASE_GREEN_RESET;
         base_blue_ff   <= BASE_BLUE_RESET;
         boost_red_ff   <= BOOST_RED_RESET;
         boost_green_ff <= BOOST_GREEN_RESET;
         boost_blue_ff  <= BOOST_BLUE_RESET;
      end else if (csr_we) begin
         case (alcb_csr_type'(csr_addr))
            CSR_BASE_RED:    base_red_ff    <= csr_wdata;
            CSR_BASE_GREEN:  base_green_ff  <= csr_wdata;
            CSR_BASE_BLUE:   base_blue_ff   <= csr_wdata;
            CSR_BOOST_RED:   boost_red_ff   <= csr_wdata;
            CSR_BOOST_GREEN: boost_green_ff <= csr_wdata;
            CSR_BOOST_BLUE:  boost_blue_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Sequencer and block state.
   alcb_state_type      state_ff, state_in;
   alcb_chan_type       chan_ff, chan_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [LEVEL_BITS-1:0] prev_ff, prev2_ff, level_ff, tval_ff;
   logic [COLOR_W-1:0]  red_ff, green_ff, blue_ff;
   logic                rsp_valid_ff;
   alcb_rsp_type        rsp_data_ff;

   logic                req_fire;
   logic                out_free;
   logic [SAMPLE_W:0]   mag_raw;
   logic [SAMPLE_W:0]   mag;
   logic [SUM_W:0]      sum_wide;
   logic [SUM_W-1:0]    acc_sum;
   logic [COUNT_W-1:0]  acc_count;
   logic                count_open;

   alcb_div_req_type    div_req;
   alcb_div_rsp_type    div_rsp;

   logic [IDX_W-1:0]            idx_full;
   logic                        idx_over;
   logic [LEVEL_BITS:0]         half_sum;
   logic [LEVEL_BITS-1:0]       level_a;
   logic [LEVEL_BITS+1:0]       quarter_sum;
   logic [LEVEL_BITS-1:0]       level_b;

   logic [COLOR_W-1:0]          sel_base;
   logic [COLOR_W-1:0]          sel_boost;
   logic signed [COLOR_W:0]     color_diff;
   logic signed [COLOR_W+LEVEL_BITS+1:0] blend_prod;
   logic signed [COLOR_W+LEVEL_BITS+2:0] blend_num;
   logic [COLOR_W-1:0]          blend_color;

   assign req_fire = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Accumulate: a sample of -1.0 gives a magnitude of exactly 1.0.
   always_comb begin
      mag_raw = req_data.sample[SAMPLE_W-1] ?
                ((SAMPLE_W + 1)'(0) - {req_data.sample[SAMPLE_W-1], req_data.sample}) :
                {1'b0, req_data.sample};
      mag        = (mag_raw > MAG_ONE) ? MAG_ONE : mag_raw;
      sum_wide   = {1'b0, sum_ff} + (SUM_W + 1)'(mag);
      count_open = count_ff < COUNT_W'(MAX_FRAMES);
      acc_sum    = count_open ? (sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0])
                              : sum_ff;
      acc_count  = count_open ? count_ff + 1'b1 : count_ff;
   end

   always_comb begin
      div_req.start    = req_fire && req_data.block_end;
      div_req.dividend = acc_sum;
      div_req.divisor  = acc_count;
   end

   alcb_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Table index from the mean; a mean of 1.0 runs past the table.
   always_comb begin
      idx_full = IDX_W'(div_rsp.quotient >> IDX_RSHIFT) << IDX_LSHIFT;
      idx_over = |idx_full[IDX_W-1:TABLE_INDEX_BITS];
   end

   // Smoothing: average with the last level, then a quarter of the one before.
   always_comb begin
      half_sum    = {1'b0, tval_ff} + {1'b0, prev_ff};
      level_a     = half_sum[LEVEL_BITS:1];
      quarter_sum = {2'b00, level_a} + {1'b0, level_a, 1'b0} + {2'b00, prev2_ff};
      level_b     = quarter_sum[LEVEL_BITS+1:2];
   end

   // Shared blend multiplier, one channel per cycle.
   always_comb begin
      case (chan_ff)
         CH_RED: begin
            sel_base  = base_red_ff;
            sel_boost = boost_red_ff;
         end
         CH_GREEN: begin
            sel_base  = base_green_ff;
            sel_boost = boost_green_ff;
         end
         CH_BLUE: begin
            sel_base  = base_blue_ff;
            sel_boost = boost_blue_ff;
         end
         default: begin
            sel_base  = base_red_ff;
            sel_boost = boost_red_ff;
         end
      endcase
      color_diff  = $signed({1'b0, sel_boost}) - $signed({1'b0, sel_base});
      blend_prod  = color_diff * $signed({1'b0, level_ff});
      blend_num   = $signed({3'b000, sel_base, {LEVEL_BITS{1'b0}}})
                  + (COLOR_W + LEVEL_BITS + 3)'(blend_prod);
      blend_color = blend_num[LEVEL_BITS+COLOR_W-1:LEVEL_BITS];
   end

   always_comb begin
      state_in  = state_ff;
      chan_in   = chan_ff;
      sum_in    = sum_ff;
      count_in  = count_ff;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_fire) begin
               if (req_data.block_end) begin
                  sum_in   = '0;
                  count_in = '0;
                  state_in = ST_DIV;
               end else begin
                  sum_in   = acc_sum;
                  count_in = acc_count;
               end
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               state_in = ST_LEVEL;
            end
         end
         ST_LEVEL: begin
            chan_in  = CH_RED;
            state_in = ST_BLEND;
         end
         ST_BLEND: begin
            case (chan_ff)
               CH_RED:   chan_in = CH_GREEN;
               CH_GREEN: chan_in = CH_BLUE;
               default:  state_in = ST_OUT;
            endcase
         end
         ST_OUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         chan_ff  <= CH_RED;
         sum_ff   <= '0;
         count_ff <= '0;
         prev_ff  <= '0;
         prev2_ff <= '0;
      end else begin
         state_ff <= state_in;
         chan_ff  <= chan_in;
         sum_ff   <= sum_in;
         count_ff <= count_in;
         if (state_ff == ST_LEVEL) begin
            prev2_ff <= prev_ff;
            prev_ff  <= level_b;
         end
      end
   end

   // Table read is registered; the level and channel bytes are payload.
   always_ff @(posedge clock) begin
      if (state_ff == ST_DIV && div_rsp.done) begin
         tval_ff <= idx_over ? LEVEL_BITS'(LEVEL_MAX)
                             : POW_TABLE[idx_full[TABLE_INDEX_BITS-1:0]];
      end
      if (state_ff == ST_LEVEL) begin
         level_ff <= level_b;
      end
      if (state_ff == ST_BLEND) begin
         case (chan_ff)
            CH_RED:   red_ff   <= blend_color;
            CH_GREEN: green_ff <= blend_color;
            CH_BLUE:  blue_ff  <= blend_color;
            default: ;
         endcase
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_OUT && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_OUT && out_free) begin
         rsp_data_ff.red   <= red_ff;
         rsp_data_ff.green <= green_ff;
         rsp_data_ff.blue  <= blue_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: dv/audio_level_color_blend_tb.sv
// -----------------------------------------------------------------------------
// audio_level_color_blend_tb
// Self-checking testbench for the audio level color blender. A queue-fed driver
// offers sample frames in random bursts, an independent model predicts the
// color of every closed block, and a monitor checks each response in order
// while the response side stalls on its own pattern.
// -----------------------------------------------------------------------------
module audio_level_color_blend_tb;
   import alcb_pkg::*;

   localparam int FRAC_BITS  = 23;
   localparam int LVL_BITS   = 16;
   localparam int IDX_BITS   = 10;
   localparam int FRAME_CAP  = 4096;
   localparam int SUM_BITS   = 35;
   localparam int ROOT_NUM   = 33;
   localparam int ROOT_DEN   = 50;
   localparam real ROOT_EXP  = 0.66;
   localparam longint FULL_SCALE = 64'sd1 << FRAC_BITS;
   localparam longint SUM_CEIL   = (64'sd1 << SUM_BITS) - 1;
   localparam int TBL_SIZE   = 1 << IDX_BITS;
   localparam int LVL_MAX    = (1 << LVL_BITS) - 1;
   localparam int WIDE_BITS  = ROOT_DEN * LVL_BITS + 2;

   localparam int NUM_COLOR_REGS = CSR_BOOST_BLUE + 1;
   localparam logic [CSR_ADDR_W-1:0] CSR_SPARE_FIRST = CSR_ADDR_W'(NUM_COLOR_REGS);
   localparam logic [CSR_ADDR_W-1:0] CSR_SPARE_LAST  = {CSR_ADDR_W{1'b1}};

   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7fffff;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'sh800000;

   localparam int RANDOM_FRAMES = 950;
   localparam int RANDOM_PHASES = 6;
   localparam int MIN_BLOCKS    = 10;
   localparam int SETTLE_CYCLES = 120;
   localparam int DRAIN_LIMIT   = 5000;
   localparam int HOLD_CYCLES   = 400;
   localparam int MAX_PRINTED   = 40;
   localparam int RUN_LIMIT     = 20000000;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_TOGGLE
   } stall_mode_type;

   typedef enum logic [1:0] {
      MIX_NOISE,
      MIX_SPREAD,
      MIX_STEADY,
      MIX_EXTREME
   } block_mix_type;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   alcb_req_type          req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   alcb_rsp_type          rsp_data;
   logic                  csr_we    = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr  = '0;
   logic [COLOR_W-1:0]    csr_wdata = '0;

   // Model state.
   logic [LVL_BITS-1:0] pow_table [TBL_SIZE];
   logic [COLOR_W-1:0]  color_reg [NUM_COLOR_REGS];
   longint              level_sum = 0;
   int                  level_frames = 0;
   int unsigned         level_last = 0;
   int unsigned         level_before = 0;

   alcb_req_type pending_frames [$];
   alcb_rsp_type expected_rgb [$];
   alcb_rsp_type rgb_due;

   int error_count   = 0;
   int frames_sent   = 0;
   int blocks_closed = 0;
   int colors_seen   = 0;
   int settings_used = 0;
   int input_stalls  = 0;
   int output_stalls = 0;

   int burst_left = 0;
   int gap_left   = 0;
   int gap_pick;

   int             hold_seq  = 0;
   int             hold_seen = 0;
   int             hold_left = 0;
   int             mode_left = 0;
   stall_mode_type stall_mode = STALL_NONE;

   audio_level_color_blend DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   always #2 clock = ~clock;

   task automatic report_error(input string what);
      error_count++;
      if (error_count <= MAX_PRINTED) begin
         $display("ERROR @%0t: %s", $time, what);
      end
   endtask

   function automatic bit [WIDE_BITS-1:0] wide_pow(input int unsigned x, input int unsigned ex);
      bit [WIDE_BITS-1:0] acc;
      acc = 1;
      for (int b = 7; b >= 0; b--) begin
         acc = acc * acc;
         if (ex[b]) begin
            acc = acc * x;
         end
      end
      return acc;
   endfunction

   // A real-valued guess is nudged until y^50 <= (i/N)^33 holds exactly for y and
   // fails for y+1, all in integers scaled to the level format.
   task automatic build_pow_table();
      bit [WIDE_BITS-1:0] bound;
      int                 y;
      for (int i = 0; i < TBL_SIZE; i++) begin
         bound = wide_pow(i, ROOT_NUM) << (ROOT_DEN * LVL_BITS - ROOT_NUM * IDX_BITS);
         y = int'($floor(real'(LVL_MAX + 1) * $pow(real'(i) / real'(TBL_SIZE), ROOT_EXP)));
         if (y > LVL_MAX) y = LVL_MAX;
         if (y < 0) y = 0;
         while (y < LVL_MAX && wide_pow(y + 1, ROOT_DEN) <= bound) y++;
         while (y > 0 && wide_pow(y, ROOT_DEN) > bound) y--;
         pow_table[i] = LVL_BITS'(y);
      end
   endtask

   function automatic logic [COLOR_W-1:0] mix_channel(input logic [COLOR_W-1:0] base_c,
                                                      input logic [COLOR_W-1:0] boost_c,
                                                      input int unsigned lvl);
      longint acc;
      acc = (longint'(base_c) <<< LVL_BITS) + (longint'(boost_c) - longint'(base_c)) * longint'(lvl);
      if (acc < 0) acc = 0;
      return COLOR_W'(acc >>> LVL_BITS);
   endfunction

   task automatic absorb_frame(input alcb_req_type frame);
      longint       mag;
      longint       mean;
      longint       idx;
      int unsigned  shaped;
      int unsigned  half;
      int unsigned  lvl;
      alcb_rsp_type rgb;
      mag = longint'($signed(frame.sample));
      if (mag < 0) mag = -mag;
      if (mag > FULL_SCALE) mag = FULL_SCALE;
      // Frames past the cap still close the block but add nothing.
      if (level_frames < FRAME_CAP) begin
         level_sum = level_sum + mag;
         if (level_sum > SUM_CEIL) level_sum = SUM_CEIL;
         level_frames++;
      end
      if (frame.block_end) begin
         mean   = level_sum / level_frames;
         idx    = mean >> (FRAC_BITS - IDX_BITS);
         shaped = (idx >= TBL_SIZE) ? LVL_MAX : pow_table[idx];
         half   = (shaped + level_last) >> 1;
         lvl    = (3 * half + level_before) >> 2;
         level_before = level_last;
         level_last   = lvl;
         rgb.red   = mix_channel(color_reg[CSR_BASE_RED], color_reg[CSR_BOOST_RED], lvl);
         rgb.green = mix_channel(color_reg[CSR_BASE_GREEN], color_reg[CSR_BOOST_GREEN], lvl);
         rgb.blue  = mix_channel(color_reg[CSR_BASE_BLUE], color_reg[CSR_BOOST_BLUE], lvl);
         expected_rgb.push_back(rgb);
         level_sum    = 0;
         level_frames = 0;
         blocks_closed++;
      end
   endtask

   function automatic void queue_frame(input logic signed [SAMPLE_W-1:0] s, input logic closes);
      alcb_req_type f;
      f.sample    = s;
      f.block_end = closes;
      pending_frames.push_back(f);
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] signed_mag(input int unsigned m);
      if ($urandom_range(0, 1) == 1) begin
         return SAMPLE_W'(-longint'(m));
      end
      return (m > SAMPLE_MAX) ? SAMPLE_MAX : SAMPLE_W'(m);
   endfunction

   function automatic int queue_random_block();
      int                          len;
      int                          pick;
      int unsigned                 amp;
      block_mix_type               mix;
      logic signed [SAMPLE_W-1:0]  s;
      pick = $urandom_range(0, 99);
      if (pick < 15) len = 1;
      else if (pick < 85) len = $urandom_range(2, 12);
      else if (pick < 98) len = $urandom_range(13, 80);
      else len = $urandom_range(81, 400);
      mix = block_mix_type'($urandom_range(0, 3));
      // Half the blocks get a power-of-two amplitude so quiet means show up too.
      if ($urandom_range(0, 1) == 1) amp = $urandom_range(0, 1 << FRAC_BITS);
      else amp = 1 << $urandom_range(0, FRAC_BITS);
      for (int k = 0; k < len; k++) begin
         case (mix)
            MIX_NOISE: s = SAMPLE_W'($urandom);
            MIX_SPREAD: s = signed_mag($urandom_range(0, amp));
            MIX_STEADY: s = signed_mag(amp);
            default: begin
               case ($urandom_range(0, 5))
                  0: s = SAMPLE_MIN;
                  1: s = SAMPLE_MAX;
                  2: s = '0;
                  3: s = 24'sd1;
                  4: s = -24'sd1;
                  default: s = SAMPLE_MIN + 24'sd1;
               endcase
            end
         endcase
         if ($urandom_range(0, 19) == 0) s = SAMPLE_W'($urandom);
         queue_frame(s, k == len - 1);
      end
      return len;
   endfunction

   task automatic write_palette(input logic [3*COLOR_W-1:0] base_rgb,
                                input logic [3*COLOR_W-1:0] boost_rgb);
      logic [COLOR_W-1:0] vals [NUM_COLOR_REGS];
      vals[CSR_BASE_RED]    = base_rgb[2*COLOR_W +: COLOR_W];
      vals[CSR_BASE_GREEN]  = base_rgb[COLOR_W +: COLOR_W];
      vals[CSR_BASE_BLUE]   = base_rgb[0 +: COLOR_W];
      vals[CSR_BOOST_RED]   = boost_rgb[2*COLOR_W +: COLOR_W];
      vals[CSR_BOOST_GREEN] = boost_rgb[COLOR_W +: COLOR_W];
      vals[CSR_BOOST_BLUE]  = boost_rgb[0 +: COLOR_W];
      for (int r = 0; r < NUM_COLOR_REGS; r++) begin
         @(posedge clock);
         csr_we    <= 1'b1;
         csr_addr  <= CSR_ADDR_W'(r);
         csr_wdata <= vals[r];
         color_reg[r] = vals[r];
      end
      // Writes to unmapped indexes come last so any aliasing would show.
      for (int r = CSR_SPARE_FIRST; r <= CSR_SPARE_LAST; r++) begin
         @(posedge clock);
         csr_we    <= 1'b1;
         csr_addr  <= CSR_ADDR_W'(r);
         csr_wdata <= COLOR_W'($urandom);
      end
      @(posedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
      settings_used++;
   endtask

   task automatic wait_idle();
      int waited;
      waited = 0;
      do @(negedge clock); while (pending_frames.size() != 0 || req_valid);
      while (expected_rgb.size() != 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Request driver: bursts of random length separated by random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         burst_left = 0;
         gap_left   = 0;
      end else begin
         if (req_valid && req_stall) input_stalls++;
         if (req_valid && !req_stall) begin
            absorb_frame(req_data);
            frames_sent++;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_frames.size() != 0) begin
               req_data  <= pending_frames.pop_front();
               req_valid <= 1'b1;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 40);
                  gap_pick   = $urandom_range(0, 9);
                  if (gap_pick < 5) gap_left = 0;
                  else if (gap_pick < 9) gap_left = $urandom_range(1, 4);
                  else gap_left = $urandom_range(5, 40);
               end else begin
                  burst_left--;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response stall pattern, with a long hold whenever the stimulus asks for one.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && rsp_stall) output_stalls++;
         if (hold_seen != hold_seq) begin
            hold_seen = hold_seq;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            if (mode_left == 0) begin
               mode_left  = $urandom_range(16, 96);
               stall_mode = stall_mode_type'($urandom_range(0, 3));
            end else begin
               mode_left--;
            end
            case (stall_mode)
               STALL_NONE:  rsp_stall <= 1'b0;
               STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
               STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
               default:     rsp_stall <= ~rsp_stall;
            endcase
         end
      end
   end

   // Response checker.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rgb.size() == 0) begin
            report_error($sformatf("unexpected color %h", rsp_data));
         end else begin
            rgb_due = expected_rgb.pop_front();
            colors_seen++;
            if (rsp_data.red !== rgb_due.red) begin
               report_error($sformatf("block %0d red %h, expected %h",
                                      colors_seen, rsp_data.red, rgb_due.red));
            end
            if (rsp_data.green !== rgb_due.green) begin
               report_error($sformatf("block %0d green %h, expected %h",
                                      colors_seen, rsp_data.green, rgb_due.green));
            end
            if (rsp_data.blue !== rgb_due.blue) begin
               report_error($sformatf("block %0d blue %h, expected %h",
                                      colors_seen, rsp_data.blue, rgb_due.blue));
            end
         end
      end
   end

   initial begin
      int phase_frames;
      int phase_blocks;
      build_pow_table();
      color_reg[CSR_BASE_RED]    = 8'h7f;
      color_reg[CSR_BASE_GREEN]  = 8'h25;
      color_reg[CSR_BASE_BLUE]   = 8'h50;
      color_reg[CSR_BOOST_RED]   = 8'hff;
      color_reg[CSR_BOOST_GREEN] = 8'h00;
      color_reg[CSR_BOOST_BLUE]  = 8'h00;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed blocks under the reset colors.
      queue_frame('0, 1'b1);
      queue_frame(SAMPLE_MIN, 1'b1);
      queue_frame(SAMPLE_MAX, 1'b1);
      queue_frame(24'sd1, 1'b0);
      queue_frame(-24'sd1, 1'b0);
      queue_frame(SAMPLE_MIN + 24'sd1, 1'b1);
      queue_frame(24'sh555555, 1'b0);
      queue_frame(24'shaaaaaa, 1'b1);
      queue_frame(SAMPLE_MAX, 1'b0);
      queue_frame(SAMPLE_MIN, 1'b0);
      queue_frame('0, 1'b1);
      queue_frame(24'sh002000, 1'b1);
      queue_frame(24'sh001fff, 1'b1);
      repeat (3) queue_frame(24'sh400000, 1'b0);
      queue_frame(24'sh400000, 1'b1);
      wait_idle();

      // A full cap of full-scale frames saturates the sum; in the second block
      // loud frames past the cap must not move the mean.
      repeat (FRAME_CAP + 1) queue_frame(SAMPLE_MIN, 1'b0);
      queue_frame(SAMPLE_MIN, 1'b1);
      repeat (FRAME_CAP) queue_frame(24'sh200000, 1'b0);
      repeat (4) queue_frame(SAMPLE_MAX, 1'b0);
      queue_frame(SAMPLE_MIN, 1'b1);
      wait_idle();

      // Short blocks against a long response hold so the input side backs up.
      write_palette(24'h0000ff, 24'hff0000);
      hold_seq++;
      repeat (12) begin
         queue_frame(signed_mag($urandom_range(0, 1 << FRAC_BITS)), 1'b0);
         queue_frame(signed_mag($urandom_range(0, 1 << FRAC_BITS)), 1'b0);
         queue_frame(signed_mag($urandom_range(0, 1 << FRAC_BITS)), 1'b1);
      end
      wait_idle();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: write_palette(24'h000000, 24'h000000);
            1: write_palette(24'hffffff, 24'hffffff);
            2: write_palette(24'h000000, 24'hffffff);
            3: write_palette(24'hffffff, 24'h000000);
            default: write_palette(24'($urandom), 24'($urandom));
         endcase
         phase_frames = 0;
         phase_blocks = 0;
         while (phase_frames < RANDOM_FRAMES / RANDOM_PHASES || phase_blocks < MIN_BLOCKS) begin
            phase_frames += queue_random_block();
            phase_blocks++;
         end
         wait_idle();
      end

      if (expected_rgb.size() != 0) begin
         report_error($sformatf("%0d expected colors never arrived", expected_rgb.size()));
      end
      $display("Covered %0d frames in %0d blocks under %0d color settings, incl. two blocks past",
               frames_sent, blocks_closed, settings_used);
      $display("the frame cap; input waited %0d cycles, output was held %0d cycles.",
               input_stalls, output_stalls);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #(RUN_LIMIT);
      $display("Timed out with %0d colors still expected.", expected_rgb.size());
      $display("DONE: errors detected");
      $finish;
   end

endmodule

// File: audio_level_color_blend.f
sv/alcb_pkg.sv
sv/alcb_divider.sv
sv/audio_level_color_blend.sv
dv/audio_level_color_blend_tb.sv
